// ===== sv/assert_macros.svh =====
// Assertion macros used by cbhp_ctrl, the sequencer of the high-pass biquad cascade.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/cbhp_pkg.sv =====
// Package for the high-pass biquad cascade: widths, register indexes,
// controller command types and the saturation helpers. No dependencies.
`default_nettype none

package cbhp_pkg;

  localparam int SECTIONS         = 2;
  localparam int SEC_W            = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int NSEC_W           = 2;
  localparam int COEF_W           = 32;
  localparam int SAMPLE_W         = 24;
  localparam int FRAC_W           = 16;
  localparam int W_W              = 40;   // Q24.16 delay word
  localparam int DIFF_W           = 42;   // w0 - 2*w1 + w2
  localparam int LO_W             = 16;   // low slice of a multiplier operand
  localparam int OPD_W            = DIFF_W - LO_W + 1;  // signed multiplier operand
  localparam int PROD_W           = COEF_W + OPD_W;
  localparam int ACC_W            = PROD_W + LO_W;
  localparam int Q_SHIFT          = 30;
  localparam int RND_W            = ACC_W - Q_SHIFT;
  localparam int OUT_PRE_W        = W_W + 1 - FRAC_W;
  localparam int CFG_IDX_W        = 3;
  localparam int REGS_PER_SECTION = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SECTIONS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_ONE_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB_TWO_FIRST    = 3'd3;

  localparam logic [NSEC_W-1:0] SECTIONS_RESET = NSEC_W'(SECTIONS);

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [1:0] {
    TERM_FB1  = 2'b00,
    TERM_FB2  = 2'b01,
    TERM_GAIN = 2'b10
  } term_t;

  typedef struct packed {
    logic             load_input;
    logic [SEC_W-1:0] sec;
    term_t            term;
    logic             hi;
    logic             mul_en;
    logic             acc_load;
    logic             acc_add;
    logic             sum_load;
    logic             w0_store;
    logic             diff_store;
    logic             sec_done;
    logic             out_load;
  } dp_cmd_t;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_P1L  = 13'b0000000000010,
    S_P1H  = 13'b0000000000100,
    S_P2L  = 13'b0000000001000,
    S_P2H  = 13'b0000000010000,
    S_P2A  = 13'b0000000100000,
    S_W0   = 13'b0000001000000,
    S_DIFF = 13'b0000010000000,
    S_P3L  = 13'b0000100000000,
    S_P3H  = 13'b0001000000000,
    S_P3A  = 13'b0010000000000,
    S_Y    = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic                  hit;
    logic signed [W_W-1:0] val;
  } sat40_t;

  typedef struct packed {
    logic                       hit;
    logic signed [SAMPLE_W-1:0] val;
  } sat24_t;

  function automatic sat40_t sat_w40(input logic signed [RND_W-1:0] v);
    sat40_t r;
    r.hit = 1'b0;
    r.val = v[W_W-1:0];
    if (!v[RND_W-1] && (|v[RND_W-2:W_W-1])) begin
      r.hit = 1'b1;
      r.val = {1'b0, {(W_W-1){1'b1}}};
    end else if (v[RND_W-1] && !(&v[RND_W-2:W_W-1])) begin
      r.hit = 1'b1;
      r.val = {1'b1, {(W_W-1){1'b0}}};
    end
    return r;
  endfunction

  function automatic sat24_t sat_out(input logic signed [OUT_PRE_W-1:0] v);
    sat24_t r;
    r.hit = 1'b0;
    r.val = v[SAMPLE_W-1:0];
    if (!v[OUT_PRE_W-1] && (|v[OUT_PRE_W-2:SAMPLE_W-1])) begin
      r.hit = 1'b1;
      r.val = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (v[OUT_PRE_W-1] && !(&v[OUT_PRE_W-2:SAMPLE_W-1])) begin
      r.hit = 1'b1;
      r.val = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cascaded_biquad_highpass.sv =====
// Cascaded high-pass biquad filter (direct form II, up to two sections).
// A new sample is taken only in idle, after the previous one has been loaded
// into the output register; throughput is set by the single shared multiplier
// doing six partial products per section.
// Reset (synchronous, rst_n low): delays cleared, two sections, coefficients zero.
// Depends on cbhp_pkg, cbhp_ctrl and cbhp_dp.
`default_nettype none

module cascaded_biquad_highpass (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // sample input
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [cbhp_pkg::SAMPLE_W-1:0]  in_sample,
  // filtered output
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [cbhp_pkg::SAMPLE_W-1:0]       out_filtered,
  output logic                                       out_clipped,
  // register writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [cbhp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [cbhp_pkg::COEF_W-1:0]           cfg_data
);

  // Each section runs w0 = d1*w1 + d2*w2 + x, then y = A*(w0 - 2*w1 + w2).
  // Every coefficient product is 32 bits by up to 42 bits, so the sequencer
  // splits the delay operand into a 16-bit unsigned low slice and a signed
  // high slice and runs them in turn through one 32x27 multiplier.
  // The datapath accumulates low + round + (high << 16) and takes bits [74:30],
  // which gives the round-half-up Q2.30 product exactly.
  //
  // Register map: index 0 is the section count, then three coefficients per
  // section (gain, first feedback, second feedback). Writes to other indexes
  // are dropped. Registers accept a write on every cycle.

  logic [cbhp_pkg::NSEC_W-1:0] sections_r, sections_nxt;
  cbhp_pkg::coef_t             gain_r   [cbhp_pkg::SECTIONS];
  cbhp_pkg::coef_t             fb_one_r [cbhp_pkg::SECTIONS];
  cbhp_pkg::coef_t             fb_two_r [cbhp_pkg::SECTIONS];
  cbhp_pkg::coef_t             gain_nxt   [cbhp_pkg::SECTIONS];
  cbhp_pkg::coef_t             fb_one_nxt [cbhp_pkg::SECTIONS];
  cbhp_pkg::coef_t             fb_two_nxt [cbhp_pkg::SECTIONS];
  logic                        cfg_write;
  cbhp_pkg::dp_cmd_t           cmd;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Decode a register write; the section offset advances the base index.
  always_comb begin
    sections_nxt = sections_r;
    for (int s = 0; s < cbhp_pkg::SECTIONS; s++) begin
      gain_nxt[s]   = gain_r[s];
      fb_one_nxt[s] = fb_one_r[s];
      fb_two_nxt[s] = fb_two_r[s];
    end
    if (cfg_write) begin
      if (cfg_index == cbhp_pkg::REG_SECTIONS_IN_USE) begin
        sections_nxt = cfg_data[cbhp_pkg::NSEC_W-1:0];
      end
      for (int s = 0; s < cbhp_pkg::SECTIONS; s++) begin
        if (cfg_index == cbhp_pkg::CFG_IDX_W'(cbhp_pkg::REG_GAIN_FIRST
                         + cbhp_pkg::REGS_PER_SECTION * s)) begin
          gain_nxt[s] = cfg_data;
        end
        if (cfg_index == cbhp_pkg::CFG_IDX_W'(cbhp_pkg::REG_FB_ONE_FIRST
                         + cbhp_pkg::REGS_PER_SECTION * s)) begin
          fb_one_nxt[s] = cfg_data;
        end
        if (cfg_index == cbhp_pkg::CFG_IDX_W'(cbhp_pkg::REG_FB_TWO_FIRST
                         + cbhp_pkg::REGS_PER_SECTION * s)) begin
          fb_two_nxt[s] = cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sections_r <= cbhp_pkg::SECTIONS_RESET;
      for (int s = 0; s < cbhp_pkg::SECTIONS; s++) begin
        gain_r[s]   <= '0;
        fb_one_r[s] <= '0;
        fb_two_r[s] <= '0;
      end
    end else begin
      sections_r <= sections_nxt;
      for (int s = 0; s < cbhp_pkg::SECTIONS; s++) begin
        gain_r[s]   <= gain_nxt[s];
        fb_one_r[s] <= fb_one_nxt[s];
        fb_two_r[s] <= fb_two_nxt[s];
      end
    end
  end

  // Sequencer: takes a transfer in idle, walks each active section through
  // its eleven steps, then loads the output register once it is free.
  cbhp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .n_sections (sections_r),
    .cmd        (cmd)
  );

  // Arithmetic, delay state and the output register.
  cbhp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_sample    (in_sample),
    .gain         (gain_r),
    .fb_one       (fb_one_r),
    .fb_two       (fb_two_r),
    .out_filtered (out_filtered),
    .out_clipped  (out_clipped)
  );

endmodule

`default_nettype wire

// ===== sv/cbhp_ctrl.sv =====
// Sequencer for the biquad cascade: steps the shared multiplier through the
// three products of each section and owns the handshakes. Uses cbhp_pkg.
`default_nettype none
`include "assert_macros.svh"

module cbhp_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  input  wire logic [cbhp_pkg::NSEC_W-1:0] n_sections,
  output cbhp_pkg::dp_cmd_t                cmd
);

  cbhp_pkg::state_t                state_r, state_nxt;
  logic [cbhp_pkg::SEC_W-1:0]      k_r, k_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [cbhp_pkg::NSEC_W-1:0]     eff_sections;
  logic [cbhp_pkg::SEC_W-1:0]      last_sec;

  // Clamp the section count to 1..SECTIONS
  always_comb begin
    if (n_sections == '0) begin
      eff_sections = cbhp_pkg::NSEC_W'(1);
    end else if (n_sections > cbhp_pkg::NSEC_W'(cbhp_pkg::SECTIONS)) begin
      eff_sections = cbhp_pkg::NSEC_W'(cbhp_pkg::SECTIONS);
    end else begin
      eff_sections = n_sections;
    end
    last_sec = cbhp_pkg::SEC_W'(eff_sections - cbhp_pkg::NSEC_W'(1));
  end

  assign in_stall  = (state_r != cbhp_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.sec       = k_r;
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      cbhp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_input = 1'b1;
          k_nxt          = '0;
          state_nxt      = cbhp_pkg::S_P1L;
        end
      end
      cbhp_pkg::S_P1L: begin
        cmd.term   = cbhp_pkg::TERM_FB1;
        cmd.mul_en = 1'b1;
        state_nxt  = cbhp_pkg::S_P1H;
      end
      cbhp_pkg::S_P1H: begin
        cmd.term     = cbhp_pkg::TERM_FB1;
        cmd.hi       = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.acc_load = 1'b1;
        state_nxt    = cbhp_pkg::S_P2L;
      end
      cbhp_pkg::S_P2L: begin
        cmd.term    = cbhp_pkg::TERM_FB2;
        cmd.mul_en  = 1'b1;
        cmd.acc_add = 1'b1;
        state_nxt   = cbhp_pkg::S_P2H;
      end
      cbhp_pkg::S_P2H: begin
        cmd.term     = cbhp_pkg::TERM_FB2;
        cmd.hi       = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.acc_load = 1'b1;
        cmd.sum_load = 1'b1;
        state_nxt    = cbhp_pkg::S_P2A;
      end
      cbhp_pkg::S_P2A: begin
        cmd.acc_add = 1'b1;
        state_nxt   = cbhp_pkg::S_W0;
      end
      cbhp_pkg::S_W0: begin
        cmd.w0_store = 1'b1;
        state_nxt    = cbhp_pkg::S_DIFF;
      end
      cbhp_pkg::S_DIFF: begin
        cmd.diff_store = 1'b1;
        state_nxt      = cbhp_pkg::S_P3L;
      end
      cbhp_pkg::S_P3L: begin
        cmd.term   = cbhp_pkg::TERM_GAIN;
        cmd.mul_en = 1'b1;
        state_nxt  = cbhp_pkg::S_P3H;
      end
      cbhp_pkg::S_P3H: begin
        cmd.term     = cbhp_pkg::TERM_GAIN;
        cmd.hi       = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.acc_load = 1'b1;
        state_nxt    = cbhp_pkg::S_P3A;
      end
      cbhp_pkg::S_P3A: begin
        cmd.acc_add = 1'b1;
        state_nxt   = cbhp_pkg::S_Y;
      end
      cbhp_pkg::S_Y: begin
        cmd.sec_done = 1'b1;
        if (k_r == last_sec) begin
          state_nxt = cbhp_pkg::S_OUT;
        end else begin
          k_nxt     = k_r + cbhp_pkg::SEC_W'(1);
          state_nxt = cbhp_pkg::S_P1L;
        end
      end
      cbhp_pkg::S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cbhp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cbhp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbhp_pkg::S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_NEXT(a_accept_starts_first, in_valid && !in_stall, (state_r == cbhp_pkg::S_P1L) && (k_r == '0))
  `ASSERT_NEXT(a_last_goes_out, (state_r == cbhp_pkg::S_Y) && (k_r == last_sec), state_r == cbhp_pkg::S_OUT)
  `ASSERT_NEXT(a_out_waits, (state_r == cbhp_pkg::S_OUT) && out_valid_r && out_stall, state_r == cbhp_pkg::S_OUT)
  `ASSERT_IMPL(a_sec_in_range, state_r != cbhp_pkg::S_IDLE, k_r <= last_sec)

endmodule

`default_nettype wire

// ===== sv/cbhp_dp.sv =====
// Datapath for the biquad cascade: shared 32x27 multiplier, Q2.30 rounding
// accumulator, per-section delays, saturation and output register. Uses cbhp_pkg.
`default_nettype none

module cbhp_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire cbhp_pkg::dp_cmd_t                    cmd,
  input  wire logic signed [cbhp_pkg::SAMPLE_W-1:0] in_sample,
  input  wire cbhp_pkg::coef_t                      gain [cbhp_pkg::SECTIONS],
  input  wire cbhp_pkg::coef_t                      fb_one [cbhp_pkg::SECTIONS],
  input  wire cbhp_pkg::coef_t                      fb_two [cbhp_pkg::SECTIONS],
  output logic signed [cbhp_pkg::SAMPLE_W-1:0]      out_filtered,
  output logic                                      out_clipped
);

  logic signed [cbhp_pkg::W_W-1:0]       delay_one_r [cbhp_pkg::SECTIONS];
  logic signed [cbhp_pkg::W_W-1:0]       delay_two_r [cbhp_pkg::SECTIONS];
  logic signed [cbhp_pkg::W_W-1:0]       x_r, w0_r;
  logic signed [cbhp_pkg::DIFF_W-1:0]    diff_r;
  logic signed [cbhp_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic signed [cbhp_pkg::ACC_W-1:0]     acc_r;
  logic signed [cbhp_pkg::RND_W-1:0]     sum_r;
  logic                                  clip_r;
  logic signed [cbhp_pkg::SAMPLE_W-1:0]  filtered_r;
  logic                                  clipped_r;

  logic signed [cbhp_pkg::W_W-1:0]       w1, w2;
  cbhp_pkg::coef_t                       coef;
  logic signed [cbhp_pkg::DIFF_W-1:0]    opd;
  logic signed [cbhp_pkg::OPD_W-1:0]     mul_b;
  logic signed [cbhp_pkg::RND_W-1:0]     rnd;
  logic signed [cbhp_pkg::RND_W-1:0]     w0_sum;
  logic signed [cbhp_pkg::DIFF_W-1:0]    diff_nxt;
  logic signed [cbhp_pkg::W_W:0]         out_biased;
  cbhp_pkg::sat40_t                      w0_sat, y_sat;
  cbhp_pkg::sat24_t                      out_sat;

  always_comb begin
    w1 = delay_one_r[cmd.sec];
    w2 = delay_two_r[cmd.sec];
    case (cmd.term)
      cbhp_pkg::TERM_FB1: begin
        coef = fb_one[cmd.sec];
        opd  = cbhp_pkg::DIFF_W'(w1);
      end
      cbhp_pkg::TERM_FB2: begin
        coef = fb_two[cmd.sec];
        opd  = cbhp_pkg::DIFF_W'(w2);
      end
      default: begin
        coef = gain[cmd.sec];
        opd  = diff_r;
      end
    endcase
    // low slice unsigned, high slice keeps the sign
    if (cmd.hi) begin
      mul_b = {opd[cbhp_pkg::DIFF_W-1], opd[cbhp_pkg::DIFF_W-1:cbhp_pkg::LO_W]};
    end else begin
      mul_b = {{(cbhp_pkg::OPD_W-cbhp_pkg::LO_W){1'b0}}, opd[cbhp_pkg::LO_W-1:0]};
    end
    prod_nxt = coef * mul_b;

    rnd        = acc_r[cbhp_pkg::ACC_W-1:cbhp_pkg::Q_SHIFT];
    w0_sum     = sum_r + rnd;
    w0_sat     = cbhp_pkg::sat_w40(w0_sum);
    y_sat      = cbhp_pkg::sat_w40(rnd);
    diff_nxt   = cbhp_pkg::DIFF_W'(w0_r) - (cbhp_pkg::DIFF_W'(w1) <<< 1)
               + cbhp_pkg::DIFF_W'(w2);
    out_biased = (cbhp_pkg::W_W+1)'(x_r)
               + (cbhp_pkg::W_W+1)'(1 << (cbhp_pkg::FRAC_W - 1));
    out_sat    = cbhp_pkg::sat_out(out_biased[cbhp_pkg::W_W:cbhp_pkg::FRAC_W]);
  end

  // Arithmetic payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      x_r <= {in_sample, {cbhp_pkg::FRAC_W{1'b0}}};
    end else if (cmd.sec_done) begin
      x_r <= y_sat.val;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_load) begin
      acc_r <= cbhp_pkg::ACC_W'(prod_r)
             + cbhp_pkg::ACC_W'(1 << (cbhp_pkg::Q_SHIFT - 1));
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {prod_r, {cbhp_pkg::LO_W{1'b0}}};
    end
    if (cmd.sum_load) begin
      sum_r <= cbhp_pkg::RND_W'(x_r) + rnd;
    end
    if (cmd.w0_store) begin
      w0_r <= w0_sat.val;
    end
    if (cmd.diff_store) begin
      diff_r <= diff_nxt;
    end
    if (cmd.out_load) begin
      filtered_r <= out_sat.val;
      clipped_r  <= clip_r | out_sat.hit;
    end
  end

  // Filter state and saturation flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < cbhp_pkg::SECTIONS; s++) begin
        delay_one_r[s] <= '0;
        delay_two_r[s] <= '0;
      end
      clip_r <= 1'b0;
    end else begin
      if (cmd.load_input) begin
        clip_r <= 1'b0;
      end else if (cmd.w0_store) begin
        clip_r <= clip_r | w0_sat.hit;
      end else if (cmd.sec_done) begin
        clip_r <= clip_r | y_sat.hit;
      end
      if (cmd.sec_done) begin
        delay_two_r[cmd.sec] <= delay_one_r[cmd.sec];
        delay_one_r[cmd.sec] <= w0_r;
      end
    end
  end

  assign out_filtered = filtered_r;
  assign out_clipped  = clipped_r;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for cascaded_biquad_highpass: directed corner tests, then random traffic.
// Holds its own fixed-point filter predictor and checks every output transfer against it.
// Depends on cbhp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;

  // Register indexes beyond the ones the package names.
  localparam logic [cbhp_pkg::CFG_IDX_W-1:0] REG_GAIN_SECOND   = 3'd4;
  localparam logic [cbhp_pkg::CFG_IDX_W-1:0] REG_FB_ONE_SECOND = 3'd5;
  localparam logic [cbhp_pkg::CFG_IDX_W-1:0] REG_FB_TWO_SECOND = 3'd6;
  localparam logic [cbhp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED      = 3'd7;

  localparam int WIDE_W      = 48;      // headroom for sums before saturation
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_GAP   = 32;

  localparam logic signed [cbhp_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
    {1'b0, {(cbhp_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic signed [cbhp_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
    {1'b1, {(cbhp_pkg::SAMPLE_W-1){1'b0}}};
  localparam logic signed [cbhp_pkg::COEF_W-1:0]   COEF_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [cbhp_pkg::COEF_W-1:0]   COEF_MIN   = 32'sh8000_0000;
  localparam logic signed [cbhp_pkg::COEF_W-1:0]   COEF_ONE   = 32'sh4000_0000;

  localparam logic signed [WIDE_W-1:0] DELAY_HI = (48'sd1 <<< (cbhp_pkg::W_W-1)) - 48'sd1;
  localparam logic signed [WIDE_W-1:0] DELAY_LO = -(48'sd1 <<< (cbhp_pkg::W_W-1));
  localparam logic signed [WIDE_W-1:0] OUT_HI   = (48'sd1 <<< (cbhp_pkg::SAMPLE_W-1)) - 48'sd1;
  localparam logic signed [WIDE_W-1:0] OUT_LO   = -(48'sd1 <<< (cbhp_pkg::SAMPLE_W-1));

  typedef struct packed {
    logic signed [cbhp_pkg::SAMPLE_W-1:0] filtered;
    logic                                 clipped;
  } filter_out_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [cbhp_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [cbhp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cbhp_pkg::COEF_W-1:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  logic signed [cbhp_pkg::SAMPLE_W-1:0] out_filtered;
  logic out_clipped;
  logic cfg_ready;

  cascaded_biquad_highpass dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .out_clipped  (out_clipped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor copy of the registers and the delay line.
  logic [cbhp_pkg::NSEC_W-1:0]        sections_cfg;
  logic signed [cbhp_pkg::COEF_W-1:0] gain_coef [cbhp_pkg::SECTIONS];
  logic signed [cbhp_pkg::COEF_W-1:0] fb1_coef  [cbhp_pkg::SECTIONS];
  logic signed [cbhp_pkg::COEF_W-1:0] fb2_coef  [cbhp_pkg::SECTIONS];
  logic signed [cbhp_pkg::W_W-1:0]    w1_state  [cbhp_pkg::SECTIONS];
  logic signed [cbhp_pkg::W_W-1:0]    w2_state  [cbhp_pkg::SECTIONS];
  logic                               clip_seen;

  filter_out_t expected_outputs [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int signal_level = 0;

  // ---------------------------------------------------------------------------
  // Filter predictor
  // ---------------------------------------------------------------------------

  task automatic reset_model();
    int k;
    sections_cfg = cbhp_pkg::SECTIONS_RESET;
    for (k = 0; k < cbhp_pkg::SECTIONS; k++) begin
      gain_coef[k] = '0;
      fb1_coef[k]  = '0;
      fb2_coef[k]  = '0;
      w1_state[k]  = '0;
      w2_state[k]  = '0;
    end
  endtask

  // Q2.30 coefficient times Q24.16 word, rounded half up back to Q24.16.
  function automatic logic signed [WIDE_W-1:0] scale_q30(
      input logic signed [cbhp_pkg::COEF_W-1:0] c,
      input logic signed [WIDE_W-1:0] v);
    logic signed [79:0] p;
    p = c * v;
    p = p + (80'sd1 <<< (cbhp_pkg::Q_SHIFT-1));
    return p[cbhp_pkg::Q_SHIFT +: WIDE_W];
  endfunction

  // Saturate into [lo, hi]; note any hit for the clipped flag.
  function automatic logic signed [WIDE_W-1:0] clamp_to(input logic signed [WIDE_W-1:0] v,
                                                        input logic signed [WIDE_W-1:0] lo,
                                                        input logic signed [WIDE_W-1:0] hi);
    if (v > hi) begin
      clip_seen = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip_seen = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic filter_out_t filter_sample(input logic signed [cbhp_pkg::SAMPLE_W-1:0] s);
    filter_out_t r;
    logic signed [WIDE_W-1:0] x, acc, diff;
    logic signed [cbhp_pkg::W_W-1:0] w0;
    int n, k;
    clip_seen = 1'b0;
    // A count of zero runs one section, anything above the build runs them all.
    if (sections_cfg == '0)
      n = 1;
    else if (int'(sections_cfg) > cbhp_pkg::SECTIONS)
      n = cbhp_pkg::SECTIONS;
    else
      n = int'(sections_cfg);
    x = s;
    x = x <<< cbhp_pkg::FRAC_W;
    for (k = 0; k < n; k++) begin
      acc = scale_q30(fb1_coef[k], w1_state[k]) + scale_q30(fb2_coef[k], w2_state[k]) + x;
      w0 = cbhp_pkg::W_W'(clamp_to(acc, DELAY_LO, DELAY_HI));
      diff = w0 - 48'sd2 * w1_state[k] + w2_state[k];
      x = clamp_to(scale_q30(gain_coef[k], diff), DELAY_LO, DELAY_HI);
      w2_state[k] = w1_state[k];
      w1_state[k] = w0;
    end
    acc = (x + (48'sd1 <<< (cbhp_pkg::FRAC_W-1))) >>> cbhp_pkg::FRAC_W;
    acc = clamp_to(acc, OUT_LO, OUT_HI);
    r.filtered = acc[cbhp_pkg::SAMPLE_W-1:0];
    r.clipped  = clip_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, handshakes sampled on the rising edge
  // ---------------------------------------------------------------------------

  // Write one register and mirror it in the predictor once the transfer happens.
  task automatic cfg_write(input logic [cbhp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cbhp_pkg::COEF_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cbhp_pkg::REG_SECTIONS_IN_USE: sections_cfg = data[cbhp_pkg::NSEC_W-1:0];
      cbhp_pkg::REG_GAIN_FIRST:      gain_coef[0] = data;
      cbhp_pkg::REG_FB_ONE_FIRST:    fb1_coef[0]  = data;
      cbhp_pkg::REG_FB_TWO_FIRST:    fb2_coef[0]  = data;
      REG_GAIN_SECOND:               gain_coef[1] = data;
      REG_FB_ONE_SECOND:             fb1_coef[1]  = data;
      REG_FB_TWO_SECOND:             fb2_coef[1]  = data;
      default: ;  // unmapped index: the block drops the write
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_section(input int k, input logic [cbhp_pkg::COEF_W-1:0] g,
                             input logic [cbhp_pkg::COEF_W-1:0] f1,
                             input logic [cbhp_pkg::COEF_W-1:0] f2);
    cfg_write(cbhp_pkg::CFG_IDX_W'(cbhp_pkg::REG_GAIN_FIRST
                                   + k * cbhp_pkg::REGS_PER_SECTION), g);
    cfg_write(cbhp_pkg::CFG_IDX_W'(cbhp_pkg::REG_FB_ONE_FIRST
                                   + k * cbhp_pkg::REGS_PER_SECTION), f1);
    cfg_write(cbhp_pkg::CFG_IDX_W'(cbhp_pkg::REG_FB_TWO_FIRST
                                   + k * cbhp_pkg::REGS_PER_SECTION), f2);
  endtask

  // Offer one sample, wait for its transfer, then queue its predicted output.
  // Valid stays high after the transfer; the next send or a drain updates it
  // at the very next falling edge.
  task automatic send_sample(input logic signed [cbhp_pkg::SAMPLE_W-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!(in_valid && !in_stall));
    expected_outputs.push_back(filter_sample(s));
  endtask

  // Drop valid and hold off until every queued output has come back, then let
  // the pipeline settle.
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : check_outputs
    filter_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("output transfer with nothing queued, filtered=%0d",
                                  out_filtered));
      end else begin
        want = expected_outputs.pop_front();
        if (out_filtered !== want.filtered)
          report_mismatch($sformatf("filtered got %0d want %0d", out_filtered, want.filtered));
        if (out_clipped !== want.clipped)
          report_mismatch($sformatf("clipped got %0b want %0b (filtered %0d)",
                                    out_clipped, want.clipped, want.filtered));
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly a wandering signal, with full-range noise, rail hits and zeros mixed in.
  function automatic logic signed [cbhp_pkg::SAMPLE_W-1:0] next_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) begin
      signal_level = signal_level + int'($urandom_range(0, 400000)) - 200000;
      if (signal_level > 8388607) signal_level = 8388607;
      if (signal_level < -8388608) signal_level = -8388608;
      return signal_level[cbhp_pkg::SAMPLE_W-1:0];
    end
    if (pick < 85) return cbhp_pkg::SAMPLE_W'($urandom());
    if (pick < 95) return pick[0] ? SAMPLE_MAX : SAMPLE_MIN;
    return '0;
  endfunction

  function automatic logic [cbhp_pkg::COEF_W-1:0] corner_coef();
    case ($urandom_range(3))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return '0;
      default: return COEF_ONE;
    endcase
  endfunction

  // Draw a fresh register set: a stable high-pass shape, tiny values, full-range
  // noise or rail values. The section count is drawn over all four codes.
  task automatic apply_random_settings();
    logic signed [cbhp_pkg::COEF_W-1:0] g, f1, f2;
    int mode, k;
    mode = $urandom_range(3);
    cfg_write(cbhp_pkg::REG_SECTIONS_IN_USE, $urandom());
    for (k = 0; k < cbhp_pkg::SECTIONS; k++) begin
      case (mode)
        0: begin
          g  = $urandom_range(751619277, 1073741824);   // 0.70 .. 1.00
          f1 = $urandom_range(1288490189, 1664299827);  // 1.20 .. 1.55
          f2 = $urandom_range(644245094, 1020054733);   // -(0.60 .. 0.95)
          f2 = -f2;
        end
        1: begin
          g  = int'($urandom_range(0, 536870912)) - 268435456;
          f1 = int'($urandom_range(0, 1073741824)) - 536870912;
          f2 = int'($urandom_range(0, 1073741824)) - 536870912;
        end
        2: begin
          g  = $urandom();
          f1 = $urandom();
          f2 = $urandom();
        end
        default: begin
          g  = corner_coef();
          f1 = corner_coef();
          f2 = corner_coef();
        end
      endcase
      set_section(k, g, f1, f2);
    end
    if ($urandom_range(3) == 0)
      cfg_write(REG_UNMAPPED, $urandom());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero coefficients out of reset: every sample filters to zero.
  task automatic test_reset_state();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    wait_results_done();
  endtask

  // Unity gain, no feedback: plain second difference per section. Walk the
  // count through one, zero (runs one), three (runs all), and make sure an
  // unmapped write changes nothing.
  task automatic test_section_count();
    set_section(0, COEF_ONE, '0, '0);
    set_section(1, COEF_ONE, '0, '0);
    cfg_write(REG_UNMAPPED, $urandom());
    cfg_write(cbhp_pkg::REG_SECTIONS_IN_USE, 32'd1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    wait_results_done();
    cfg_write(cbhp_pkg::REG_SECTIONS_IN_USE, 32'd0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    wait_results_done();
    cfg_write(cbhp_pkg::REG_SECTIONS_IN_USE, 32'd3);
    send_sample(SAMPLE_MAX);
    send_sample(24'sd12345);
    wait_results_done();
  endtask

  // Push the output rail, the section-output rail and the delay rail.
  task automatic test_saturation();
    int i;
    cfg_write(cbhp_pkg::REG_SECTIONS_IN_USE, 32'd2);
    set_section(0, COEF_MAX, '0, '0);
    set_section(1, COEF_MAX, '0, '0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    wait_results_done();
    // Feedback near +2 on both taps: the delay word runs away and pins.
    set_section(0, COEF_MIN, COEF_MAX, COEF_MAX);
    set_section(1, COEF_MIN, COEF_MAX, COEF_MAX);
    for (i = 0; i < 5; i++) send_sample(SAMPLE_MAX);
    wait_results_done();
    // Feedback at -2: alternate rails to drive the delay negative.
    set_section(0, COEF_ONE, COEF_MIN, COEF_MIN);
    set_section(1, COEF_MAX, COEF_MIN, COEF_MIN);
    for (i = 0; i < 4; i++) send_sample(i[0] ? SAMPLE_MAX : SAMPLE_MIN);
    wait_results_done();
  endtask

  // Random traffic under one idling profile, reconfigured every segment. Each
  // reconfiguration first stops the sender until all outputs are back.
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int items);
    int seg, i, per_seg;
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
    per_seg       = items / 4;
    for (seg = 0; seg < 4; seg++) begin
      wait_results_done();
      apply_random_settings();
      for (i = 0; i < per_seg; i++) send_sample(next_sample());
    end
    wait_results_done();
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_section_count();
    test_saturation();
    test_random_traffic(27, 86, 484);
    test_random_traffic(86, 27, 484);
    test_random_traffic(0, 0, 484);

    stall_pct = 0;
    wait_results_done();
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
